// ===== design/box_muller_gaussian_sample_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the Box-Muller sample generator
// Shared concurrent assertion forms, clocked on clk, with rst as reset.
// ---------------------------------------------------------------------------
`ifndef BOX_MULLER_GAUSSIAN_SAMPLE_DEFINES_SVH
`define BOX_MULLER_GAUSSIAN_SAMPLE_DEFINES_SVH

// A condition that must hold at every edge outside reset.
`define BMG_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

// A condition that must hold whenever its antecedent holds.
`define BMG_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// A condition that must hold at the edge after any reset edge.
`define BMG_ASSERT_AFTER_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bmg_pkg.sv =====
// ---------------------------------------------------------------------------
// Box-Muller sample generator package
// Widths, fixed-point constants, series tables and shared types.
// ---------------------------------------------------------------------------
`default_nettype none

package bmg_pkg;

  // Port widths and register reset.
  localparam int unsigned INDEX_W     = 14;
  localparam int unsigned SIGMA_W     = 16;
  localparam int unsigned SAMPLE_W    = 24;
  localparam int unsigned MAG_W       = 23;
  localparam logic [SIGMA_W-1:0] SIGMA_RESET = 16'd256;
  localparam int unsigned SAMPLE_LIMIT = 4504000;

  // Parameter defaults.
  localparam int unsigned UNIFORM_LEVELS_DEF = 10001;
  localparam int unsigned FRAC_BITS_DEF      = 12;

  // Internal datapath widths.
  localparam int unsigned Q_SHIFT    = 30;
  localparam int unsigned PROD_W     = 24;
  localparam int unsigned NUM_W      = PROD_W + Q_SHIFT;
  localparam int unsigned ANGLE_STEP = 628;
  localparam int unsigned ANGLE_SCALE = 100;
  localparam int unsigned DIV_STAGES = 3;
  localparam int unsigned LEAD_W     = $clog2(INDEX_W);
  localparam int unsigned LOG_ROUNDS = 24;
  localparam int unsigned LOG_W      = LEAD_W + LOG_ROUNDS;
  localparam int unsigned DIFF_W     = 29;
  localparam int unsigned RAD_W      = 30;
  localparam int unsigned ROOT_W     = 27;
  localparam int unsigned REM_W      = 29;
  localparam int unsigned COS_W      = 31;
  localparam int unsigned X2_W       = 32;
  localparam int unsigned MID_W      = 28;
  localparam int unsigned RECIP_W    = 33;
  localparam int unsigned SERIES_N   = 6;
  localparam int unsigned RADIUS_LAT = 1 + LOG_ROUNDS + 2 + ROOT_W;

  // Fixed-point constants in Q30.
  localparam logic [30:0] ONE_Q30           = 31'h4000_0000;
  localparam logic [30:0] TWO_LN2_Q30       = 31'd1488522236;
  localparam logic [32:0] HALF_PI_Q30       = 33'd1686629713;
  localparam logic [32:0] PI_Q30            = 33'd3373259426;
  localparam logic [32:0] THREE_HALF_PI_Q30 = 33'd5059889139;
  localparam logic [32:0] TWO_PI_Q30        = 33'd6746518852;

  // Cosine series divisors 132, 90, 56, 30, 12, 2 as ceil(2^S/d) and S.
  localparam logic [RECIP_W-1:0] SERIES_RECIP [SERIES_N] = '{
    33'd8329633544, 33'd6108397933, 33'd4908534053,
    33'd4581298450, 33'd5726623062, 33'd4294967296
  };
  localparam int unsigned SERIES_SHIFT [SERIES_N] = '{40, 39, 38, 37, 36, 33};

  // One input beat after classification.
  typedef struct packed {
    logic [INDEX_W-1:0] radius_index;
    logic [INDEX_W-1:0] angle_index;
    logic               radius_zero;
  } bmg_beat_t;

  // Queue status seen by the front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } bmg_queue_status_t;

  // Log2 in Q24 by repeated squaring; evaluated at elaboration.
  function automatic logic [63:0] log2_q24(input logic [31:0] x);
    logic [63:0] y;
    logic [63:0] f;
    logic [63:0] n;
    n = '0;
    for (int i = 0; i < 31; i++) begin
      if ((x >> (i + 1)) != 32'd0) n = 64'(i + 1);
    end
    y = 64'(x) << (64'd30 - n);
    f = '0;
    for (int k = 0; k < 24; k++) begin
      y = (y * y) >> 30;
      f = f << 1;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        f = f | 64'd1;
      end
    end
    return (n << 24) | f;
  endfunction

  // Width of the raw angle quotient for a given number of levels.
  function automatic int unsigned theta_width(input int unsigned levels);
    return NUM_W + 1 - $clog2(ANGLE_SCALE * levels + 1);
  endfunction

  // Number of conditional subtract stages for the 2*pi reduction.
  function automatic int unsigned red_stages(input int unsigned levels);
    int unsigned tw;
    tw = theta_width(levels);
    return (tw > 33) ? (tw - 32) : 1;
  endfunction

  // Pipeline depth of the angle unit: product, reciprocal divide,
  // reduction, fold, square and two stages per series term.
  function automatic int unsigned angle_latency(input int unsigned levels);
    return 1 + DIV_STAGES + red_stages(levels) + 2 + 2 * SERIES_N;
  endfunction

endpackage

`default_nettype wire

// ===== design/box_muller_gaussian_sample.sv =====
// Pipeline: the 54-stage radius path (log2 squaring and square-root stages) is
// longer than the angle path and sets the depth of the pipeline.
// Throughput: one sample per clock, all units fully pipelined; busy stays low.
// Reset: synchronous rst clears the valid line, queue and front end; sigma_gain
// returns to 1.0. The result side has no back-pressure.
// ---------------------------------------------------------------------------
// Box-Muller Gaussian sample generator
// Turns two uniform indices into sigma*sqrt(-2 ln U1)*cos(6.28 U2) in Q.12.
// ---------------------------------------------------------------------------
`default_nettype none

module box_muller_gaussian_sample #(
  parameter int unsigned UNIFORM_LEVELS = bmg_pkg::UNIFORM_LEVELS_DEF,
  parameter int unsigned FRAC_BITS      = bmg_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [bmg_pkg::INDEX_W-1:0]         radius_index,
  input  logic [bmg_pkg::INDEX_W-1:0]         angle_index,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bmg_pkg::SIGMA_W-1:0]         cfg_data,
  output logic                                done,
  output logic signed [bmg_pkg::SAMPLE_W-1:0] sample,
  output logic                                saturated
);
  import bmg_pkg::*;

  logic              sigma_write;
  logic [SIGMA_W-1:0] sigma_gain;
  logic              push;
  bmg_beat_t         push_beat;
  bmg_beat_t         head;
  bmg_queue_status_t q_status;

  // Sigma register write port.
  assign cfg_ready   = 1'b1;
  assign sigma_write = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma_gain <= SIGMA_RESET;
    end else if (sigma_write) begin
      sigma_gain <= cfg_data;
    end
  end

  bmg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .radius_index (radius_index),
    .angle_index  (angle_index),
    .q_status     (q_status),
    .busy         (busy),
    .push         (push),
    .push_beat    (push_beat)
  );

  bmg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_beat (push_beat),
    .pop       (~q_status.empty),
    .head      (head),
    .status    (q_status)
  );

  bmg_back #(
    .UNIFORM_LEVELS (UNIFORM_LEVELS),
    .FRAC_BITS      (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (~q_status.empty),
    .beat       (head),
    .sigma_gain (sigma_gain),
    .done       (done),
    .sample     (sample),
    .saturated  (saturated)
  );

endmodule

`default_nettype wire

// ===== design/bmg_front.sv =====
// ---------------------------------------------------------------------------
// Front end
// Takes a command beat, flags a zero radius index, and pushes the beat
// into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module bmg_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [bmg_pkg::INDEX_W-1:0]     radius_index,
  input  logic [bmg_pkg::INDEX_W-1:0]     angle_index,
  input  bmg_pkg::bmg_queue_status_t      q_status,
  output logic                            busy,
  output logic                            push,
  output bmg_pkg::bmg_beat_t              push_beat
);
  import bmg_pkg::*;

  logic      held;
  logic      held_next;
  bmg_beat_t beat;
  logic      accept;

  // Handshake on the command side.
  assign push   = held & ~q_status.full;
  assign busy   = held & q_status.full;
  assign accept = start & ~busy;

  always_comb begin
    held_next = held;
    if (accept) begin
      held_next = 1'b1;
    end else if (push) begin
      held_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  // Capture and classify the beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      beat.radius_index <= radius_index;
      beat.angle_index  <= angle_index;
      beat.radius_zero  <= (radius_index == '0);
    end
  end

  assign push_beat = beat;

endmodule

`default_nettype wire

// ===== design/bmg_queue.sv =====
// ---------------------------------------------------------------------------
// Beat queue
// Two-entry queue between the front end and the arithmetic back end.
// ---------------------------------------------------------------------------
`default_nettype none

module bmg_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  bmg_pkg::bmg_beat_t         push_beat,
  input  logic                       pop,
  output bmg_pkg::bmg_beat_t         head,
  output bmg_pkg::bmg_queue_status_t status
);
  import bmg_pkg::*;

  bmg_beat_t  entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign do_push      = push & ~status.full;
  assign do_pop       = pop & ~status.empty;
  assign head         = entry[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= push_beat;
  end

endmodule

`default_nettype wire

// ===== design/bmg_angle.sv =====
// ---------------------------------------------------------------------------
// Angle unit
// Forms theta = 6.28*j/L in Q30 by reciprocal multiplication with a one-step
// correction, reduces it modulo 2*pi, folds it into the first quadrant and
// evaluates |cos| with a pipelined nested series. Returns magnitude and sign.
// ---------------------------------------------------------------------------
`default_nettype none

module bmg_angle #(
  parameter int unsigned UNIFORM_LEVELS = bmg_pkg::UNIFORM_LEVELS_DEF
) (
  input  logic                          clk,
  input  logic [bmg_pkg::INDEX_W-1:0]   angle_index,
  output logic [bmg_pkg::COS_W-1:0]     cos_mag,
  output logic                          cos_neg
);
  import bmg_pkg::*;

  localparam int unsigned DIVISOR = ANGLE_SCALE * UNIFORM_LEVELS;
  localparam int unsigned DIV_W   = $clog2(DIVISOR + 1);
  localparam int unsigned CMP_W   = DIV_W + 1;
  localparam int unsigned PP_W    = 2 * PROD_W;
  localparam int unsigned THETA_W = theta_width(UNIFORM_LEVELS);
  localparam int unsigned RED_N   = red_stages(UNIFORM_LEVELS);
  localparam logic [63:0]        RECIP    = (64'd1 << NUM_W) / 64'(DIVISOR);
  localparam logic [PROD_W-1:0]  RECIP_LO = PROD_W'(RECIP);
  localparam logic [PROD_W-1:0]  RECIP_HI = PROD_W'(RECIP >> PROD_W);
  localparam logic [CMP_W-1:0]   DIV_K    = CMP_W'(DIVISOR);

  logic [PROD_W-1:0]  prod;
  logic [PP_W-1:0]    pp_lo;
  logic [PP_W-1:0]    pp_hi;
  logic [THETA_W-1:0] q_est;
  logic [CMP_W-1:0]   qd_low;
  logic [CMP_W-1:0]   rem_est;
  logic [THETA_W-1:0] theta;
  logic [THETA_W-1:0] rd_t    [RED_N];
  logic [32:0]        fold_in;
  logic [30:0]        fx;
  logic               fneg;
  logic [X2_W-1:0]    x2;
  logic               x2_neg;
  logic [X2_W-1:0]    ca_v   [SERIES_N];
  logic [X2_W-1:0]    ca_x2  [SERIES_N];
  logic               ca_neg [SERIES_N];
  logic [COS_W-1:0]   cb_t   [SERIES_N];
  logic [X2_W-1:0]    cb_x2  [SERIES_N];
  logic               cb_neg [SERIES_N];

  // Scaled angle numerator 628*j.
  always_ff @(posedge clk) begin
    prod <= PROD_W'(32'(angle_index) * 32'(ANGLE_STEP));
  end

  // Quotient estimate prod * floor(2^54/D) >> 24, split into two partial
  // products. The estimate is the true quotient or one below it.
  always_ff @(posedge clk) begin
    pp_lo <= PP_W'(prod) * PP_W'(RECIP_LO);
    pp_hi <= PP_W'(prod) * PP_W'(RECIP_HI);
  end

  always_ff @(posedge clk) begin
    q_est <= THETA_W'(pp_hi + PP_W'(pp_lo[PP_W-1:PROD_W]));
  end

  // The numerator has thirty zero low bits, so the low bits of the
  // remainder follow from the low bits of q_est*D alone.
  assign qd_low  = q_est[CMP_W-1:0] * DIV_K;
  assign rem_est = {CMP_W{1'b0}} - qd_low;

  always_ff @(posedge clk) begin
    if (rem_est >= DIV_K) begin
      theta <= q_est + THETA_W'(1);
    end else begin
      theta <= q_est;
    end
  end

  // Reduction modulo 2*pi by conditional subtraction of scaled multiples.
  for (genvar j = 0; j < RED_N; j++) begin : g_red
    localparam logic [63:0] MOD_SH = 64'(TWO_PI_Q30) << (RED_N - 1 - j);
    logic [THETA_W-1:0] t_in;

    if (j == 0) begin : g_first
      assign t_in = theta;
    end else begin : g_next
      assign t_in = rd_t[j-1];
    end

    always_ff @(posedge clk) begin
      if (64'(t_in) >= MOD_SH) begin
        rd_t[j] <= THETA_W'(64'(t_in) - MOD_SH);
      end else begin
        rd_t[j] <= t_in;
      end
    end
  end

  // Quadrant fold into [0, pi/2] with the cosine sign.
  assign fold_in = 33'(rd_t[RED_N-1]);

  always_ff @(posedge clk) begin
    if (fold_in <= HALF_PI_Q30) begin
      fx   <= 31'(fold_in);
      fneg <= 1'b0;
    end else if (fold_in <= PI_Q30) begin
      fx   <= 31'(PI_Q30 - fold_in);
      fneg <= 1'b1;
    end else if (fold_in <= THREE_HALF_PI_Q30) begin
      fx   <= 31'(fold_in - PI_Q30);
      fneg <= 1'b1;
    end else begin
      fx   <= 31'(TWO_PI_Q30 - fold_in);
      fneg <= 1'b0;
    end
  end

  // Square of the folded angle.
  always_ff @(posedge clk) begin
    x2     <= X2_W'((64'(fx) * 64'(fx)) >> Q_SHIFT);
    x2_neg <= fneg;
  end

  // Nested series: a product stage and a divide-by-constant stage per term.
  for (genvar k = 0; k < SERIES_N; k++) begin : g_cos
    logic [X2_W-1:0]  x2_in;
    logic [COS_W-1:0] t_in;
    logic             neg_in;
    logic [64:0]      quo;

    if (k == 0) begin : g_first
      assign x2_in  = x2;
      assign t_in   = ONE_Q30;
      assign neg_in = x2_neg;
    end else begin : g_next
      assign x2_in  = cb_x2[k-1];
      assign t_in   = cb_t[k-1];
      assign neg_in = cb_neg[k-1];
    end

    always_ff @(posedge clk) begin
      ca_v[k]   <= X2_W'((64'(x2_in) * 64'(t_in)) >> Q_SHIFT);
      ca_x2[k]  <= x2_in;
      ca_neg[k] <= neg_in;
    end

    assign quo = (65'(ca_v[k]) * 65'(SERIES_RECIP[k])) >> SERIES_SHIFT[k];

    always_ff @(posedge clk) begin
      if (quo < 65'(ONE_Q30)) begin
        cb_t[k] <= COS_W'(65'(ONE_Q30) - quo);
      end else begin
        cb_t[k] <= '0;
      end
      cb_x2[k]  <= ca_x2[k];
      cb_neg[k] <= ca_neg[k];
    end
  end

  assign cos_mag = cb_t[SERIES_N-1];
  assign cos_neg = cb_neg[SERIES_N-1];

endmodule

`default_nettype wire

// ===== design/bmg_radius.sv =====
// ---------------------------------------------------------------------------
// Radius unit
// Computes floor(sqrt(2 ln2 * (log2 L - log2 i))) in Q24 with a pipelined
// log2 by repeated squaring and a pipelined digit-by-digit square root.
// ---------------------------------------------------------------------------
`default_nettype none

module bmg_radius #(
  parameter int unsigned UNIFORM_LEVELS = bmg_pkg::UNIFORM_LEVELS_DEF
) (
  input  logic                          clk,
  input  logic [bmg_pkg::INDEX_W-1:0]   radius_index,
  output logic [bmg_pkg::ROOT_W-1:0]    root
);
  import bmg_pkg::*;

  localparam logic [DIFF_W-1:0] LOG_LEVELS = DIFF_W'(log2_q24(32'(UNIFORM_LEVELS)));

  logic [LEAD_W-1:0]     lead;
  logic [30:0]           nm_y;
  logic [LEAD_W-1:0]     nm_n;
  logic [30:0]           lg_y [LOG_ROUNDS];
  logic [LOG_ROUNDS-1:0] lg_f [LOG_ROUNDS];
  logic [LEAD_W-1:0]     lg_n [LOG_ROUNDS];
  logic [DIFF_W-1:0]     log_i;
  logic [DIFF_W-1:0]     diff;
  logic [RAD_W-1:0]      rad;
  logic [ROOT_W-1:0]     rt_root [ROOT_W];
  logic [REM_W-1:0]      rt_rem  [ROOT_W];
  logic [RAD_W-1:0]      rt_rad  [ROOT_W];

  // Leading one position.
  always_comb begin
    lead = '0;
    for (int i = 0; i < INDEX_W; i++) begin
      if (radius_index[i]) lead = LEAD_W'(i);
    end
  end

  // Normalize the index to a Q30 mantissa in [1, 2).
  always_ff @(posedge clk) begin
    nm_y <= 31'(32'(radius_index) << (5'd30 - 5'(lead)));
    nm_n <= lead;
  end

  // One fraction bit of log2 per squaring stage.
  for (genvar k = 0; k < LOG_ROUNDS; k++) begin : g_log
    logic [30:0]           y_in;
    logic [LOG_ROUNDS-1:0] f_in;
    logic [LEAD_W-1:0]     n_in;
    logic [31:0]           sq;

    if (k == 0) begin : g_first
      assign y_in = nm_y;
      assign f_in = '0;
      assign n_in = nm_n;
    end else begin : g_next
      assign y_in = lg_y[k-1];
      assign f_in = lg_f[k-1];
      assign n_in = lg_n[k-1];
    end

    assign sq = 32'((64'(y_in) * 64'(y_in)) >> Q_SHIFT);

    always_ff @(posedge clk) begin
      lg_n[k] <= n_in;
      if (sq[31]) begin
        lg_y[k] <= sq[31:1];
        lg_f[k] <= {f_in[LOG_ROUNDS-2:0], 1'b1};
      end else begin
        lg_y[k] <= sq[30:0];
        lg_f[k] <= {f_in[LOG_ROUNDS-2:0], 1'b0};
      end
    end
  end

  assign log_i = DIFF_W'({lg_n[LOG_ROUNDS-1], lg_f[LOG_ROUNDS-1]});

  // Log difference; an index at or above the level count gives zero.
  always_ff @(posedge clk) begin
    if (LOG_LEVELS > log_i) begin
      diff <= LOG_LEVELS - log_i;
    end else begin
      diff <= '0;
    end
  end

  // Radicand -2 ln U1 in Q24.
  always_ff @(posedge clk) begin
    rad <= RAD_W'((64'(diff) * 64'(TWO_LN2_Q30)) >> Q_SHIFT);
  end

  // Square root of rad << 24, one root bit per stage.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [ROOT_W-1:0] root_in;
    logic [REM_W-1:0]  rem_in;
    logic [RAD_W-1:0]  rad_in;
    logic [53:0]       wide;
    logic [30:0]       shifted;
    logic [30:0]       trial;

    if (k == 0) begin : g_first
      assign root_in = '0;
      assign rem_in  = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign root_in = rt_root[k-1];
      assign rem_in  = rt_rem[k-1];
      assign rad_in  = rt_rad[k-1];
    end

    assign wide    = {rad_in, 24'd0};
    assign shifted = {rem_in, wide[53-2*k -: 2]};
    assign trial   = 31'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      rt_rad[k] <= rad_in;
      if (shifted >= trial) begin
        rt_rem[k]  <= REM_W'(shifted - trial);
        rt_root[k] <= {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rt_rem[k]  <= REM_W'(shifted);
        rt_root[k] <= {root_in[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign root = rt_root[ROOT_W-1];

endmodule

`default_nettype wire

// ===== design/bmg_back.sv =====
// ---------------------------------------------------------------------------
// Back end
// Runs the angle and radius units side by side, aligns them, multiplies
// radius by cosine and by sigma, and applies rounding, clamping and the
// zero-radius saturation.
// ---------------------------------------------------------------------------
`default_nettype none

module bmg_back #(
  parameter int unsigned UNIFORM_LEVELS = bmg_pkg::UNIFORM_LEVELS_DEF,
  parameter int unsigned FRAC_BITS      = bmg_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  bmg_pkg::bmg_beat_t                 beat,
  input  logic [bmg_pkg::SIGMA_W-1:0]        sigma_gain,
  output logic                               done,
  output logic signed [bmg_pkg::SAMPLE_W-1:0] sample,
  output logic                               saturated
);
  import bmg_pkg::*;

  localparam int unsigned A_LAT = angle_latency(UNIFORM_LEVELS);
  localparam int unsigned P_LAT = (A_LAT > RADIUS_LAT) ? A_LAT : RADIUS_LAT;
  localparam int unsigned TOTAL = P_LAT + 2;
  localparam int unsigned C_DLY = P_LAT - A_LAT;
  localparam int unsigned R_DLY = P_LAT - RADIUS_LAT;
  localparam int unsigned SH    = 32 - FRAC_BITS;
  localparam logic [44:0] ROUND = 45'd1 << (SH - 1);
  localparam logic [MAG_W-1:0] LIMIT_MAG = MAG_W'(SAMPLE_LIMIT);

  logic [TOTAL-1:0]  vl;
  logic              zl [P_LAT];
  logic [COS_W-1:0]  cos_mag;
  logic              cos_neg;
  logic [COS_W-1:0]  cos_al;
  logic              cneg_al;
  logic [ROOT_W-1:0] root_raw;
  logic [ROOT_W-1:0] root_al;
  logic [MID_W-1:0]  m;
  logic              m_zero;
  logic              m_neg;
  logic              m_cnz;
  logic [44:0]       g_full;
  logic [44:0]       g_shift;
  logic [MAG_W-1:0]  g_mag;

  bmg_angle #(.UNIFORM_LEVELS(UNIFORM_LEVELS)) u_angle (
    .clk         (clk),
    .angle_index (beat.angle_index),
    .cos_mag     (cos_mag),
    .cos_neg     (cos_neg)
  );

  bmg_radius #(.UNIFORM_LEVELS(UNIFORM_LEVELS)) u_radius (
    .clk          (clk),
    .radius_index (beat.radius_index),
    .root         (root_raw)
  );

  // Valid line through the whole pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      vl <= '0;
    end else begin
      vl <= {vl[TOTAL-2:0], in_valid};
    end
  end

  assign done = vl[TOTAL-1];

  // Zero-radius flag follows the longer of the two paths.
  always_ff @(posedge clk) begin
    zl[0] <= beat.radius_zero;
    for (int i = 1; i < P_LAT; i++) begin
      zl[i] <= zl[i-1];
    end
  end

  // Delay the cosine result to meet the radius.
  if (C_DLY == 0) begin : g_no_cdly
    assign cos_al  = cos_mag;
    assign cneg_al = cos_neg;
  end else begin : g_cdly
    logic [COS_W-1:0] cdl [C_DLY];
    logic             cnl [C_DLY];
    always_ff @(posedge clk) begin
      cdl[0] <= cos_mag;
      cnl[0] <= cos_neg;
      for (int i = 1; i < C_DLY; i++) begin
        cdl[i] <= cdl[i-1];
        cnl[i] <= cnl[i-1];
      end
    end
    assign cos_al  = cdl[C_DLY-1];
    assign cneg_al = cnl[C_DLY-1];
  end

  // Delay the radius result to meet the cosine.
  if (R_DLY == 0) begin : g_no_dly
    assign root_al = root_raw;
  end else begin : g_dly
    logic [ROOT_W-1:0] rdl [R_DLY];
    always_ff @(posedge clk) begin
      rdl[0] <= root_raw;
      for (int i = 1; i < R_DLY; i++) begin
        rdl[i] <= rdl[i-1];
      end
    end
    assign root_al = rdl[R_DLY-1];
  end

  // Radius times cosine, rounded to Q24.
  always_ff @(posedge clk) begin
    m      <= MID_W'((64'(root_al) * 64'(cos_al) + (64'd1 << 29)) >> Q_SHIFT);
    m_zero <= zl[P_LAT-1];
    m_neg  <= cneg_al;
    m_cnz  <= (cos_al != '0);
  end

  // Sigma scaling, rounding, clamping and zero-radius override.
  always_comb begin
    g_full  = 45'(m) * 45'(sigma_gain) + ROUND;
    g_shift = g_full >> SH;
    if (m_zero) begin
      g_mag = (m_cnz && sigma_gain != '0) ? LIMIT_MAG : '0;
    end else if (g_shift > 45'(SAMPLE_LIMIT)) begin
      g_mag = LIMIT_MAG;
    end else begin
      g_mag = MAG_W'(g_shift);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (m_neg) begin
      sample <= SAMPLE_W'(0) - SAMPLE_W'(g_mag);
    end else begin
      sample <= SAMPLE_W'(g_mag);
    end
    saturated <= m_zero;
  end

endmodule

`default_nettype wire

// ===== design/bmg_checker.sv =====
// ---------------------------------------------------------------------------
// Port checker
// Watches the top-level ports of the sample generator over time.
// ---------------------------------------------------------------------------
`default_nettype none

`include "box_muller_gaussian_sample_defines.svh"

module bmg_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                busy,
  input logic                                done,
  input logic signed [bmg_pkg::SAMPLE_W-1:0] sample,
  input logic                                saturated
);
  import bmg_pkg::*;

  localparam logic signed [SAMPLE_W-1:0] LIMIT_POS = SAMPLE_W'(SAMPLE_LIMIT);
  localparam logic signed [SAMPLE_W-1:0] LIMIT_NEG = -LIMIT_POS;

  // The pipeline drains one beat per cycle, so commands are never refused.
  `BMG_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised although the queue drains every cycle")

  // Every result beat lies within the clamp limits.
  `BMG_ASSERT_IMPLY(a_sample_range, done, (sample <= LIMIT_POS) && (sample >= LIMIT_NEG), "sample outside the clamp limits")

  // A saturated beat carries zero or a full-scale value.
  `BMG_ASSERT_IMPLY(a_sat_value, done && saturated, (sample == '0) || (sample == LIMIT_POS) || (sample == LIMIT_NEG), "saturated beat with a partial value")

  // Reset empties the pipeline.
  `BMG_ASSERT_AFTER_RESET(a_reset_done, !done, "result beat right after reset")

endmodule

bind box_muller_gaussian_sample bmg_checker u_bmg_checker (
  .clk       (clk),
  .rst       (rst),
  .busy      (busy),
  .done      (done),
  .sample    (sample),
  .saturated (saturated)
);

`default_nettype wire

// ===== verif/box_muller_gaussian_sample_tb.sv =====
// ---------------------------------------------------------------------------
// Box-Muller sample generator testbench
// Drives uniform index pairs through the generator under several sigma gains,
// predicts each Q.12 sample and its saturation flag, and checks them in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// Holds predicted samples and compares them with the generator's output.
class sample_scoreboard;
  logic [23:0] sample_q[$];
  logic        sat_q[$];
  int          mismatches;

  // Notes the prediction for one accepted input beat.
  function void note_input(logic [23:0] smp, logic sat);
    sample_q.push_back(smp);
    sat_q.push_back(sat);
  endfunction

  // Compares one result beat with the oldest prediction.
  function void check_result(logic [23:0] smp, logic sat);
    logic [23:0] exp_smp;
    logic        exp_sat;
    if (sample_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Unexpected result beat: sample=%0d saturated=%0b",
                 $signed(smp), sat);
      return;
    end
    exp_smp = sample_q.pop_front();
    exp_sat = sat_q.pop_front();
    if (exp_smp !== smp || exp_sat !== sat) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Result mismatch: expected sample=%0d saturated=%0b, got %0d %0b",
                 $signed(exp_smp), exp_sat, $signed(smp), sat);
    end
  endfunction

  function int pending();
    return sample_q.size();
  endfunction
endclass

module box_muller_gaussian_sample_tb;
  import bmg_pkg::*;

  localparam longint LEVELS = 10001;
  localparam int     LATENCY = 58;
  localparam int     STALL_LIMIT = 5000;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic [INDEX_W-1:0]         radius_index;
  logic [INDEX_W-1:0]         angle_index;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [SIGMA_W-1:0]         cfg_data;
  logic                       done;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       saturated;

  logic [15:0]       gain;
  int                send_idle_pct;
  int                stall_cycles;
  bit                timed_out;
  sample_scoreboard  board;

  box_muller_gaussian_sample dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .radius_index(radius_index), .angle_index(angle_index),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .sample(sample), .saturated(saturated)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Log2 of an integer in Q24 by repeated squaring of a Q30 mantissa.
  function automatic longint unsigned log2_fixed(longint unsigned x);
    longint unsigned y, f, n;
    n = 0;
    f = 0;
    while (n < 31 && (x >> (n + 1)) != 0) n++;
    y = x << (30 - n);
    for (int k = 0; k < 24; k++) begin
      y = (y * y) >> 30;
      f = f << 1;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        f = f | 1;
      end
    end
    return (n << 24) | f;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Magnitude of the cosine on [0, pi/2] from the nested Taylor series, Q30.
  function automatic longint unsigned cos_mag(longint unsigned x);
    longint unsigned x2, t, m;
    longint unsigned divs[6];
    divs = '{132, 90, 56, 30, 12, 2};
    x2 = (x * x) >> 30;
    t = 64'd1 << 30;
    for (int k = 0; k < 6; k++) begin
      m = ((x2 * t) >> 30) / divs[k];
      t = (m < (64'd1 << 30)) ? ((64'd1 << 30) - m) : 0;
    end
    return t;
  endfunction

  // Predicts the sample and saturation flag for one index pair.
  task automatic predict_sample(input logic [13:0] ri, input logic [13:0] ai);
    longint unsigned theta, c, mag, la, lb, r, s, m;
    bit neg;
    neg = 0;
    mag = 0;
    theta = ((64'd628 * ai) << 30) / (64'd100 * LEVELS);
    theta = theta % 64'd6746518852;
    if (theta <= 64'd1686629713) begin
      c = cos_mag(theta);
    end else if (theta <= 64'd3373259426) begin
      c = cos_mag(64'd3373259426 - theta);
      neg = 1;
    end else if (theta <= 64'd5059889139) begin
      c = cos_mag(theta - 64'd3373259426);
      neg = 1;
    end else begin
      c = cos_mag(64'd6746518852 - theta);
    end
    if (ri == 0) begin
      mag = (c != 0 && gain != 0) ? SAMPLE_LIMIT : 0;
    end else begin
      la = log2_fixed(LEVELS);
      lb = log2_fixed(ri);
      if (la > lb) begin
        r = ((la - lb) * 64'd1488522236) >> 30;
        s = int_sqrt(r << 24);
        m = (s * c + (64'd1 << 29)) >> 30;
        mag = (m * gain + (64'd1 << 19)) >> 20;
        if (mag > SAMPLE_LIMIT) mag = SAMPLE_LIMIT;
      end
    end
    board.note_input(neg ? 24'(-mag) : 24'(mag), ri == 0);
  endtask

  // Sends one beat, idling first at the current rate.
  task automatic send_beat(input logic [13:0] ri, input logic [13:0] ai);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    radius_index <= ri;
    angle_index <= ai;
    do @(posedge clk); while (busy);
    predict_sample(ri, ai);
  endtask

  // Lets the pipeline drain so the register can be written safely.
  task automatic drain_pipeline();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_gain(input logic [15:0] value);
    drain_pipeline();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gain = value;
  endtask

  // Random pair; radius mostly small or mid-range, with edges now and then.
  task automatic send_random();
    logic [13:0] ri, ai;
    case ($urandom_range(9))
      0: ri = 14'($urandom_range(3));
      1: ri = 14'($urandom_range(16383, 10000));
      default: ri = 14'($urandom_range(10000));
    endcase
    ai = ($urandom_range(9) == 0) ? 14'($urandom_range(16383, 10001))
                                  : 14'($urandom_range(10000));
    send_beat(ri, ai);
  endtask

  // Sample the result bus after each edge.
  always @(posedge clk) begin
    if (!rst && done) board.check_result(sample, saturated);
  end

  // Watchdog on cycles with no accepted beat.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > STALL_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [13:0] edge_vals[6];
    logic [15:0] gains[5];
    board = new();
    timed_out = 0;
    stall_cycles = 0;
    gain = 16'd256;
    send_idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    radius_index = '0;
    angle_index = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero radius, top radius, out-of-range indices, quadrant edges.
    edge_vals = '{14'd0, 14'd1, 14'd5000, 14'd10000, 14'd10001, 14'd16383};
    foreach (edge_vals[i]) send_beat(edge_vals[i], 14'd0);
    foreach (edge_vals[i]) send_beat(14'd1, edge_vals[i]);
    send_beat(14'd0, 14'd2500);
    send_beat(14'd0, 14'd5000);
    send_beat(14'd16383, 14'd16383);
    send_beat(14'd10000, 14'd7500);
    write_gain(16'd0);
    send_beat(14'd0, 14'd0);
    send_beat(14'd1, 14'd0);
    write_gain(16'hFFFF);
    send_beat(14'd1, 14'd0);
    send_beat(14'd0, 14'd5000);
    send_beat(14'd1, 14'd5000);
    send_beat(14'd9999, 14'd9999);

    // Random phases over several gains: sender idles 29%, then 48%, then never.
    gains = '{16'd256, 16'hFFFF, 16'd1, 16'd0, 16'($urandom_range(65535))};
    for (int phase = 0; phase < 5; phase++) begin
      write_gain(gains[phase]);
      send_idle_pct = (phase < 2) ? 29 : (phase < 4) ? 48 : 0;
      for (int n = 0; n < 400; n++) send_random();
    end

    drain_pipeline();
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
